/* src/atvfp_pkg.sv */
// ----------------------------------------------------------------------------
// atvfp_pkg
// Shared types, character codes and helpers for the triple-value line parser.
// ----------------------------------------------------------------------------
package atvfp_pkg;

  // Fixed port widths
  localparam int BYTE_W = 8;
  localparam int OUT_W  = 32;

  // Characters the front end recognizes
  localparam logic [BYTE_W-1:0] CH_START = 8'h53;  // 'S'
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;  // line feed
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;  // carriage return
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  // Shortest line that can be good, counting the 'S'
  localparam int MIN_STORED = 5;

  // Token classes passed from front to back
  localparam logic [2:0] TOK_DIGIT = 3'd0;
  localparam logic [2:0] TOK_MINUS = 3'd1;
  localparam logic [2:0] TOK_PLUS  = 3'd2;
  localparam logic [2:0] TOK_DOT   = 3'd3;
  localparam logic [2:0] TOK_COMMA = 3'd4;
  localparam logic [2:0] TOK_START = 3'd5;
  localparam logic [2:0] TOK_LF    = 3'd6;
  localparam logic [2:0] TOK_OTHER = 3'd7;

  typedef struct packed {
    logic [2:0] cls;
    logic [3:0] digit;
  } tok_t;

  // Number phases
  localparam logic [1:0] PH_SIGN = 2'd0;  // sign or first integer char
  localparam logic [1:0] PH_INT  = 2'd1;  // integer digits
  localparam logic [1:0] PH_FRAC = 2'd2;  // fraction digits
  localparam logic [1:0] PH_DONE = 2'd3;  // third number ended, rest ignored

  localparam int POW_W = 20;

  // Powers of ten up to 10^6
  function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
    logic [POW_W-1:0] p;
    unique case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

/* src/atvfp_if.sv */
// ----------------------------------------------------------------------------
// atvfp interfaces
// Valid/ready channels for received bytes and for parsed value triples.
// ----------------------------------------------------------------------------
interface atvfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [atvfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atvfp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [atvfp_pkg::OUT_W-1:0] position_milli;
  logic signed [atvfp_pkg::OUT_W-1:0] velocity_milli;
  logic signed [atvfp_pkg::OUT_W-1:0] accel_milli;

  modport source (output valid, output position_milli, output velocity_milli,
                  output accel_milli, input ready);
  modport sink   (input valid, input position_milli, input velocity_milli,
                  input accel_milli, output ready);
endinterface

/* src/atvfp_front.sv */
// ----------------------------------------------------------------------------
// atvfp_front
// Accepts received bytes and turns each into a token for the parser back end.
// CR bytes are dropped here since they never affect the parse.
// ----------------------------------------------------------------------------
module atvfp_front (
  atvfp_in_if.sink       in_if,
  input  logic           q_full,
  output logic           q_push,
  output atvfp_pkg::tok_t q_tok
);
  import atvfp_pkg::*;

  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] b_off;

  assign b      = in_if.rx_byte;
  assign b_off  = b - CH_ZERO;

  // Accept whenever the queue has room
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full && (b != CH_CR);

  // Classify the word
  always_comb begin
    q_tok.digit = b_off[3:0];
    if (b >= CH_ZERO && b <= CH_NINE) begin
      q_tok.cls = TOK_DIGIT;
    end else if (b == CH_MINUS) begin
      q_tok.cls = TOK_MINUS;
    end else if (b == CH_PLUS) begin
      q_tok.cls = TOK_PLUS;
    end else if (b == CH_DOT) begin
      q_tok.cls = TOK_DOT;
    end else if (b == CH_COMMA) begin
      q_tok.cls = TOK_COMMA;
    end else if (b == CH_START) begin
      q_tok.cls = TOK_START;
    end else if (b == CH_LF) begin
      q_tok.cls = TOK_LF;
    end else begin
      q_tok.cls = TOK_OTHER;
    end
  end

endmodule

/* src/atvfp_tok_fifo.sv */
// ----------------------------------------------------------------------------
// atvfp_tok_fifo
// Two-entry token queue between front and back; full throughput when both
// sides flow, and either side may stall alone.
// ----------------------------------------------------------------------------
module atvfp_tok_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  atvfp_pkg::tok_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output atvfp_pkg::tok_t pop_tok
);
  import atvfp_pkg::*;

  tok_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_tok   = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* src/atvfp_back.sv */
// ----------------------------------------------------------------------------
// atvfp_back
// Line parser: consumes one token per cycle unless a waiting result holds back
// an LF, accumulates the scaled magnitudes and loads the result register at
// the LF of a good line.
module atvfp_back #(
  parameter int LINE_LIMIT      = 32,
  parameter int FRACTION_DIGITS = 3,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            tok_valid,
  input  atvfp_pkg::tok_t tok,
  output logic            tok_pop,
  atvfp_out_if.source     out_if
);
  import atvfp_pkg::*;

  localparam int MAG_W = VALUE_WIDTH - 1;
  localparam int SUM_W = VALUE_WIDTH + 24;
  localparam int LC_W  = $clog2(LINE_LIMIT);
  localparam int FC_W  = $clog2(FRACTION_DIGITS + 1);
  localparam int EXT_W = (VALUE_WIDTH > OUT_W) ? VALUE_WIDTH : OUT_W;
  localparam logic [SUM_W-1:0] MAX_MAG = SUM_W'({MAG_W{1'b1}});

  // Line state
  logic                   open_r, open_nxt;
  logic [LC_W-1:0]        lc_r, lc_nxt;
  logic [1:0]             fn_r, fn_nxt;
  logic [1:0]             ph_r, ph_nxt;
  logic                   started_r, started_nxt;
  logic                   bad_r, bad_nxt;
  logic                   neg_r, neg_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic [FC_W-1:0]        fc_r, fc_nxt;
  logic [VALUE_WIDTH-1:0] first_r, first_nxt;
  logic [VALUE_WIDTH-1:0] second_r, second_nxt;

  // Result register
  logic                   ov_r, ov_nxt;
  logic [VALUE_WIDTH-1:0] o_pos_r, o_pos_nxt;
  logic [VALUE_WIDTH-1:0] o_vel_r, o_vel_nxt;
  logic [VALUE_WIDTH-1:0] o_acc_r, o_acc_nxt;

  // Digit arithmetic
  logic [23:0]            int_w;
  logic [23:0]            frac_w;
  logic [SUM_W-1:0]       int_sum;
  logic [SUM_W-1:0]       frac_sum;
  logic [MAG_W-1:0]       int_mag;
  logic [MAG_W-1:0]       frac_mag;
  logic [VALUE_WIDTH-1:0] cur_val;

  assign int_w  = 24'(tok.digit) * 24'(pow10(3'(FRACTION_DIGITS)));
  assign frac_w = 24'(tok.digit) * 24'(pow10(3'(FRACTION_DIGITS - 1) - 3'(fc_r)));

  // acc*10 + weight, saturating at the largest magnitude
  assign int_sum  = (SUM_W'(mag_r) << 3) + (SUM_W'(mag_r) << 1) + SUM_W'(int_w);
  assign frac_sum = SUM_W'(mag_r) + SUM_W'(frac_w);
  assign int_mag  = (int_sum > MAX_MAG) ? MAX_MAG[MAG_W-1:0] : int_sum[MAG_W-1:0];
  assign frac_mag = (frac_sum > MAX_MAG) ? MAX_MAG[MAG_W-1:0] : frac_sum[MAG_W-1:0];

  // Signed value of the number in progress
  assign cur_val = neg_r ? (VALUE_WIDTH'(0) - {1'b0, mag_r}) : {1'b0, mag_r};

  // A waiting result only holds back the next LF
  assign tok_pop = tok_valid && (!ov_r || out_if.ready || tok.cls != TOK_LF);

  always_comb begin
    open_nxt    = open_r;
    lc_nxt      = lc_r;
    fn_nxt      = fn_r;
    ph_nxt      = ph_r;
    started_nxt = started_r;
    bad_nxt     = bad_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    fc_nxt      = fc_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    ov_nxt      = ov_r && !out_if.ready;
    o_pos_nxt   = o_pos_r;
    o_vel_nxt   = o_vel_r;
    o_acc_nxt   = o_acc_r;

    if (tok_pop) begin
      if (tok.cls == TOK_START) begin
        // 'S' opens a new line from any state
        open_nxt    = 1'b1;
        lc_nxt      = LC_W'(1);
        fn_nxt      = 2'd0;
        bad_nxt     = 1'b0;
        ph_nxt      = PH_SIGN;
        started_nxt = 1'b0;
        neg_nxt     = 1'b0;
        mag_nxt     = '0;
        fc_nxt      = '0;
      end else if (tok.cls == TOK_LF) begin
        // End of line: emit only a good one
        if (open_r && !bad_r && fn_r == 2'd2 && int'(lc_r) >= MIN_STORED &&
            int'(lc_r) < LINE_LIMIT) begin
          ov_nxt    = 1'b1;
          o_pos_nxt = first_r;
          o_vel_nxt = second_r;
          o_acc_nxt = cur_val;
        end
        open_nxt = 1'b0;
        lc_nxt   = '0;
      end else if (open_r && int'(lc_r) < LINE_LIMIT - 1) begin
        lc_nxt = LC_W'(lc_r + 1'b1);
        if (!bad_r && ph_r != PH_DONE) begin
          if (tok.cls == TOK_DIGIT) begin
            if (ph_r == PH_FRAC) begin
              // Fraction digits past the scale are dropped
              if (int'(fc_r) < FRACTION_DIGITS) begin
                mag_nxt = frac_mag;
                fc_nxt  = FC_W'(fc_r + 1'b1);
              end
            end else begin
              mag_nxt = int_mag;
              ph_nxt  = PH_INT;
            end
            started_nxt = 1'b1;
          end else if ((tok.cls == TOK_MINUS || tok.cls == TOK_PLUS) &&
                       ph_r == PH_SIGN) begin
            neg_nxt     = (tok.cls == TOK_MINUS);
            ph_nxt      = PH_INT;
            started_nxt = 1'b1;
          end else if (tok.cls == TOK_DOT && ph_r != PH_FRAC) begin
            ph_nxt      = PH_FRAC;
            started_nxt = 1'b1;
          end else if (fn_r == 2'd2) begin
            // Junk after the third number ends the parse
            ph_nxt = PH_DONE;
          end else if (tok.cls == TOK_COMMA && started_r) begin
            if (fn_r == 2'd0) begin
              first_nxt = cur_val;
            end else begin
              second_nxt = cur_val;
            end
            fn_nxt      = fn_r + 2'd1;
            ph_nxt      = PH_SIGN;
            started_nxt = 1'b0;
            neg_nxt     = 1'b0;
            mag_nxt     = '0;
            fc_nxt      = '0;
          end else begin
            bad_nxt = 1'b1;
          end
        end
      end else if (int'(lc_r) >= LINE_LIMIT - 1) begin
        // Overlong line is closed without a result
        open_nxt = 1'b0;
        lc_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      lc_r      <= '0;
      fn_r      <= 2'd0;
      ph_r      <= PH_SIGN;
      started_r <= 1'b0;
      bad_r     <= 1'b0;
      neg_r     <= 1'b0;
      mag_r     <= '0;
      fc_r      <= '0;
      first_r   <= '0;
      second_r  <= '0;
      ov_r      <= 1'b0;
    end else begin
      open_r    <= open_nxt;
      lc_r      <= lc_nxt;
      fn_r      <= fn_nxt;
      ph_r      <= ph_nxt;
      started_r <= started_nxt;
      bad_r     <= bad_nxt;
      neg_r     <= neg_nxt;
      mag_r     <= mag_nxt;
      fc_r      <= fc_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    o_pos_r <= o_pos_nxt;
    o_vel_r <= o_vel_nxt;
    o_acc_r <= o_acc_nxt;
  end

  // Sign-extend or truncate to the port width
  logic signed [EXT_W-1:0] pos_ext;
  logic signed [EXT_W-1:0] vel_ext;
  logic signed [EXT_W-1:0] acc_ext;

  assign pos_ext = EXT_W'($signed(o_pos_r));
  assign vel_ext = EXT_W'($signed(o_vel_r));
  assign acc_ext = EXT_W'($signed(o_acc_r));

  assign out_if.valid          = ov_r;
  assign out_if.position_milli = pos_ext[OUT_W-1:0];
  assign out_if.velocity_milli = vel_ext[OUT_W-1:0];
  assign out_if.accel_milli    = acc_ext[OUT_W-1:0];

endmodule

/* src/ascii_triple_value_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_triple_value_frame_parser
// Parses lines "S<a>,<b>,<c>" LF into three fixed-point values.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle, every cycle, as long as the result side
// keeps up. A byte enters a classifier, waits in a two-entry token queue and
// is parsed one token per cycle by the back end; the result for a good line
// is loaded into the output register as the back end takes its LF token from
// the queue. One result holds in that register while further bytes stream in;
// a stalled result side stops the parser at the next LF and, once the queue
// fills, the input. Each number is scaled by 10^FRACTION_DIGITS, extra
// fraction digits are cut off, and the magnitude saturates symmetrically
// at 2^(VALUE_WIDTH-1)-1. Lines of LINE_LIMIT or more stored characters are
// dropped, CR is ignored, and 'S' always starts a fresh line.
// ----------------------------------------------------------------------------
module ascii_triple_value_frame_parser #(
  parameter int LINE_LIMIT      = 32,
  parameter int FRACTION_DIGITS = 3,
  parameter int VALUE_WIDTH     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  atvfp_in_if.sink    in_if,
  atvfp_out_if.source out_if
);
  import atvfp_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  tok_t push_tok;
  tok_t pop_tok;

  // Front: accept and classify
  atvfp_front u_front (
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_tok  (push_tok)
  );

  // Token queue
  atvfp_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_tok   (pop_tok)
  );

  // Back: parse and emit
  atvfp_back #(
    .LINE_LIMIT      (LINE_LIMIT),
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .VALUE_WIDTH     (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok       (pop_tok),
    .tok_pop   (q_pop),
    .out_if    (out_if)
  );

endmodule

/* src/atvfp_checker.sv */
// ----------------------------------------------------------------------------
// atvfp_props
// Port-level checks on the parser's result channel.
// ----------------------------------------------------------------------------
module atvfp_props #(
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] position_milli,
  input logic [31:0] velocity_milli,
  input logic [31:0] accel_milli
);

  // A stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(position_milli) &&
      $stable(velocity_milli) && $stable(accel_milli))
    else $error("result payload changed while stalled");

  // No result right out of reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Saturation is symmetric: the most negative code never shows
  a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (VALUE_WIDTH <= 32) |->
      position_milli != 32'h8000_0000 && velocity_milli != 32'h8000_0000 &&
      accel_milli != 32'h8000_0000)
    else $error("asymmetric saturation in result");

endmodule

bind ascii_triple_value_frame_parser atvfp_props #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_atvfp_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .position_milli (out_if.position_milli),
  .velocity_milli (out_if.velocity_milli),
  .accel_milli    (out_if.accel_milli)
);

/* bench/atvfp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atvfp_checker
// Watches both channels of the line parser, predicts each value triple from
// the accepted bytes and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module atvfp_checker #(
  parameter int LINE_LIMIT  = 32,
  parameter int FRAC_DIGITS = 3,
  parameter int VALUE_W     = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  atvfp_in_if   in_ch,
  atvfp_out_if  out_ch,
  output int    fail_count,
  output int    pending,
  output int    results_seen
);
  import atvfp_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos;
    logic signed [OUT_W-1:0] vel;
    logic signed [OUT_W-1:0] acc;
  } triple_t;

  localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_W - 1)) - 64'd1;

  // Parser state as the byte stream leaves it
  logic        fr_open;
  int          ln_count;
  logic [1:0]  fld_num;
  logic [1:0]  phase;
  logic        started;
  logic        bad;
  logic        neg;
  logic [63:0] mag;
  int          frac_n;
  logic [63:0] val_a;
  logic [63:0] val_b;

  triple_t pending_triples[$];
  int      errors;
  int      seen;

  function automatic logic [63:0] ten_pow(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic void clear_number();
    phase   = PH_SIGN;
    started = 1'b0;
    neg     = 1'b0;
    mag     = 64'd0;
    frac_n  = 0;
  endfunction

  function automatic void reset_parser();
    fr_open  = 1'b0;
    ln_count = 0;
    fld_num  = 2'd0;
    bad      = 1'b0;
    clear_number();
    val_a    = 64'd0;
    val_b    = 64'd0;
  endfunction

  function automatic logic [63:0] current_value();
    return neg ? (64'd0 - mag) : mag;
  endfunction

  // True when the character is part of the number being parsed
  function automatic bit take_number_char(input logic [7:0] c);
    logic [63:0] add;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (phase == PH_FRAC) begin
        // digits past the kept precision are cut off
        if (frac_n < FRAC_DIGITS) begin
          add = 64'(c - CH_ZERO) * ten_pow(FRAC_DIGITS - 1 - frac_n);
          if (add > MAG_LIMIT || mag > MAG_LIMIT - add) mag = MAG_LIMIT;
          else mag = mag + add;
          frac_n++;
        end
      end else begin
        add = 64'(c - CH_ZERO) * ten_pow(FRAC_DIGITS);
        if (add > MAG_LIMIT || mag > (MAG_LIMIT - add) / 64'd10) mag = MAG_LIMIT;
        else mag = mag * 64'd10 + add;
        phase = PH_INT;
      end
      started = 1'b1;
      return 1'b1;
    end
    if ((c == CH_MINUS || c == CH_PLUS) && phase == PH_SIGN) begin
      neg     = (c == CH_MINUS);
      phase   = PH_INT;
      started = 1'b1;
      return 1'b1;
    end
    if (c == CH_DOT && phase != PH_FRAC && phase != PH_DONE) begin
      phase   = PH_FRAC;
      started = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void field_char(input logic [7:0] c);
    if (bad || phase == PH_DONE) return;
    if (take_number_char(c)) return;
    // third number: first foreign char ends it, rest is junk
    if (fld_num == 2'd2) begin
      phase = PH_DONE;
      return;
    end
    if (c == CH_COMMA && started) begin
      if (fld_num == 2'd0) val_a = current_value();
      else val_b = current_value();
      fld_num = fld_num + 2'd1;
      clear_number();
    end else begin
      bad = 1'b1;
    end
  endfunction

  // Advance the parser by one byte; returns 1 with the triple on a good LF
  function automatic bit parse_byte(input logic [7:0] c, output triple_t res);
    bit          emit;
    logic [63:0] third;
    emit = 1'b0;
    res  = '0;
    if (c == CH_START) begin
      fr_open  = 1'b1;
      ln_count = 1;
      fld_num  = 2'd0;
      bad      = 1'b0;
      clear_number();
    end else if (c == CH_LF) begin
      if (fr_open && !bad && fld_num == 2'd2 && ln_count >= MIN_STORED &&
          ln_count < LINE_LIMIT) begin
        third   = current_value();
        res.pos = val_a[OUT_W-1:0];
        res.vel = val_b[OUT_W-1:0];
        res.acc = third[OUT_W-1:0];
        emit    = 1'b1;
      end
      fr_open  = 1'b0;
      ln_count = 0;
    end else if (c == CH_CR) begin
      // carriage return never counts
    end else if (fr_open && ln_count < LINE_LIMIT - 1) begin
      ln_count++;
      field_char(c);
    end else if (ln_count >= LINE_LIMIT - 1) begin
      // overlong line: close it, ignore bytes up to the next start
      fr_open  = 1'b0;
      ln_count = 0;
    end
    return emit;
  endfunction

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
                             input logic signed [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare results first, then predict from the accepted byte
  always @(posedge clk) begin
    triple_t want;
    triple_t next_res;
    if (!rst_n) begin
      reset_parser();
      pending_triples.delete();
      errors = 0;
      seen   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen++;
        if (pending_triples.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %0d %0d %0d", $time,
                   out_ch.position_milli, out_ch.velocity_milli, out_ch.accel_milli);
          errors++;
        end else begin
          want = pending_triples.pop_front();
          check_field("position_milli", want.pos, out_ch.position_milli);
          check_field("velocity_milli", want.vel, out_ch.velocity_milli);
          check_field("accel_milli", want.acc, out_ch.accel_milli);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.rx_byte, next_res)) pending_triples.push_back(next_res);
      end
    end
    fail_count   <= errors;
    pending      <= pending_triples.size();
    results_seen <= seen;
  end

endmodule

/* bench/tb_ascii_triple_value_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_triple_value_frame_parser
// Feeds the line parser directed and random text lines under bursty input
// and a stalling result side; a checker beside the block judges the results.
// ----------------------------------------------------------------------------
module tb_ascii_triple_value_frame_parser;
  import atvfp_pkg::*;

  localparam int LINE_LIMIT   = 32;
  localparam int FRAC_DIGITS  = 3;
  localparam int VALUE_W      = 32;
  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int TIMEOUT_NS   = 1000000;

  logic clk;
  logic rst_n;

  atvfp_in_if  in_ch ();
  atvfp_out_if out_ch ();

  int fail_count;
  int pending;
  int results_seen;

  logic [7:0] txt[$];
  int         burst_left;
  int         bytes_sent;
  int         lines_sent;
  bit         hold_request;
  bit         hold_done;

  ascii_triple_value_frame_parser #(
    .LINE_LIMIT     (LINE_LIMIT),
    .FRACTION_DIGITS(FRAC_DIGITS),
    .VALUE_WIDTH    (VALUE_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  atvfp_checker #(
    .LINE_LIMIT (LINE_LIMIT),
    .FRAC_DIGITS(FRAC_DIGITS),
    .VALUE_W    (VALUE_W)
  ) scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one word, with bursts and gaps, and wait until it is taken
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_txt();
    foreach (txt[i]) push_byte(txt[i]);
    txt.delete();
    lines_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_txt();
  endtask

  // Idle the input until every predicted triple has come out
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 7))
      0:       return "x";
      1:       return " ";
      2:       return "#";
      3:       return ";";
      4:       return CH_COMMA;
      5:       return 8'h00;
      6:       return 8'hFF;
      default: return "*";
    endcase
  endfunction

  task automatic add_number(input bit may_be_empty);
    int n_int;
    int n_frac;
    int sgn;
    int start;
    start = txt.size();
    sgn = $urandom_range(0, 3);
    if (sgn == 0) txt.push_back(CH_MINUS);
    else if (sgn == 1) txt.push_back(CH_PLUS);
    // mostly short numbers, now and then enough digits to saturate
    n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 4);
    repeat (n_int) txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      txt.push_back(CH_DOT);
      n_frac = $urandom_range(0, 5);
      repeat (n_frac) txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if (txt.size() == start && !may_be_empty)
      txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic build_good_line();
    txt.push_back(CH_START);
    add_number(1'b0);
    txt.push_back(CH_COMMA);
    add_number(1'b0);
    txt.push_back(CH_COMMA);
    add_number(1'b1);
    // junk after the third number
    if ($urandom_range(0, 4) == 0) begin
      txt.push_back(junk_char());
      repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 5) == 0) txt.insert($urandom_range(1, txt.size() - 1), CH_CR);
    if ($urandom_range(0, 2) == 0) txt.push_back(CH_CR);
    txt.push_back(CH_LF);
  endtask

  // Well-formed line with one defect worked in
  task automatic build_broken_line();
    int c1;
    int c2;
    build_good_line();
    c1 = -1;
    c2 = -1;
    foreach (txt[i]) begin
      if (txt[i] == CH_COMMA) begin
        if (c1 < 0) c1 = i;
        else if (c2 < 0) c2 = i;
      end
    end
    case ($urandom_range(0, 5))
      0: txt.delete(($urandom_range(0, 1) == 0) ? c1 : c2);
      1: txt.insert($urandom_range(1, c2), junk_char());
      2: begin
        while (txt[1] != CH_COMMA) txt.delete(1);
      end
      3: begin
        while (txt.size() > c2) txt.delete(c2);
        txt.push_back(CH_LF);
      end
      4: begin
        txt.insert(c1, CH_DOT);
        txt.insert(c1, CH_DOT);
      end
      default: txt.insert($urandom_range(1, txt.size() - 1), CH_START);
    endcase
  endtask

  task automatic build_overlong_line();
    int n;
    txt.push_back(CH_START);
    n = $urandom_range(LINE_LIMIT - 3, LINE_LIMIT + 12);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) txt.push_back(CH_COMMA);
      else txt.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    txt.push_back(CH_LF);
    if ($urandom_range(0, 1) == 0) add_text("7,8,9\n");
  endtask

  // Result side: ready pattern in modes, plus one long hold on request
  initial begin : result_side
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 160);
        end
        mode_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 7) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int pick;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    burst_left    = 0;
    bytes_sent    = 0;
    lines_sent    = 0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, saturation edges, truncation, lone sign or dot
    send_text("S0,0,0\n");
    send_text("S2147483.647,-2147483.6479,0\n");
    send_text("S2147483.648,1,-2147484\n");
    send_text("S99999999,-99999999,+.9999\n");
    send_text("S000123.4560,7,8\n");
    send_text("S-,+,.\n");
    send_text("S1,2,\n");
    send_text("S1,2,3xyz,9\n");
    send_text("S+5.5,-0.001,-\r\n");
    // malformed first or second number
    send_text("S1,,3\n");
    send_text("S,1,2\n");
    send_text("S1;2,3\n");
    send_text("S1.2.3,4,5\n");
    send_text("S--1,2,3\n");
    send_text("S1,2\n");
    // CR anywhere, restart inside a line, text outside a line
    send_text("S1\r2,3,4\r\n");
    send_text("S1,2S5,6,7\n");
    send_text("5,6,7\n");
    send_text("\n");
    // longest line kept, then one stored char too many
    add_text("S1,2,");
    repeat (LINE_LIMIT - 6) txt.push_back("9");
    add_text("\n");
    send_txt();
    add_text("S1,2,");
    repeat (LINE_LIMIT - 5) txt.push_back("9");
    add_text("\n1,2,3\n");
    send_txt();
    // zero byte ends the third number, a high byte breaks the first
    add_text("S1,2,3");
    txt.push_back(8'h00);
    add_text("\n");
    send_txt();
    add_text("S1");
    txt.push_back(8'hFF);
    add_text(",2,3\n");
    send_txt();

    // random lines
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (!hold_done && bytes_sent > RANDOM_BYTES / 2) begin
        // long result stall while input keeps coming, then a full drain
        hold_done = 1'b1;
        hold_request = 1'b1;
        repeat (12) begin
          build_good_line();
          send_txt();
        end
        pause_until_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 68) build_good_line();
      else if (pick < 80) build_broken_line();
      else if (pick < 87) build_overlong_line();
      else if (pick < 95) repeat ($urandom_range(1, 20)) txt.push_back(8'($urandom_range(0, 255)));
      else if (pick < 97) add_text("\n");
      else add_text("1,2,3\n");
      send_txt();
    end

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d text chunks, %0d random words, %0d triples checked", lines_sent,
             bytes_sent, results_seen);
    $display("tb: covered saturation, truncation, junk, CR, restarts, overlong lines, stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      if (pending != 0) $display("%0t ns: %0d expected triples never arrived", $time, pending);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
